>>> design/sprc_pkg.sv
// shared types, codes and helpers for the segment pair relation classifier
package sprc_pkg;

  // endpoint code: off line, beyond an end, at an end, inside
  typedef logic signed [2:0] code_t;

  localparam code_t CODE_OFF_POS    = 3'sd3;
  localparam code_t CODE_OFF_NEG    = -3'sd3;
  localparam code_t CODE_BEYOND_END = 3'sd2;
  localparam code_t CODE_BEYOND_BEG = -3'sd2;
  localparam code_t CODE_AT_END     = 3'sd1;
  localparam code_t CODE_AT_BEG     = -3'sd1;
  localparam code_t CODE_INSIDE     = 3'sd0;

  // relation classes; the duplicate collinear class is never produced
  typedef enum logic [3:0] {
    CLS_CROSS      = 4'd0,
    CLS_TEE        = 4'd1,
    CLS_CORNER     = 4'd2,
    CLS_END_TO_END = 4'd3,
    CLS_COVER      = 4'd4,
    CLS_OVERLAP    = 4'd5,
    CLS_IDENTICAL  = 4'd7,
    CLS_NONE       = 4'd8
  } class_t;

  // the four endpoint codes of one pair
  typedef struct packed {
    code_t first_start;
    code_t first_end;
    code_t second_start;
    code_t second_end;
  } code_set_t;

  // magnitude of a code, 0..3
  function automatic logic [1:0] code_mag(input code_t c);
    logic [2:0] neg;
    begin
      neg = 3'(-c);
      code_mag = c[2] ? neg[1:0] : c[1:0];
    end
  endfunction

endpackage

>>> design/sprc_point_code.sv
// code of one point against one segment from cross, dot and length signs
module sprc_point_code #(
  parameter int COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0] p_x,
  input  logic signed [COORD_BITS-1:0] p_y,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  output sprc_pkg::code_t              code
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] ux, uy, wx, wy, dbx, dby;
  logic signed [PW-1:0] cr1, cr2, dt1, dt2, sqa1, sqa2, sqb1, sqb2;
  logic signed [PW:0]   cross_sum, dot;
  logic [PW:0]          len_a, len_b;
  logic                 at_start;

  always_comb begin
    ux  = DW'(b_x) - DW'(a_x);
    uy  = DW'(b_y) - DW'(a_y);
    wx  = DW'(p_x) - DW'(a_x);
    wy  = DW'(p_y) - DW'(a_y);
    dbx = DW'(b_x) - DW'(p_x);
    dby = DW'(b_y) - DW'(p_y);
  end

  // wx, wy point from a to p; the dot product uses b - p, so the sign flips
  assign cr1  = wx * uy;
  assign cr2  = ux * wy;
  assign dt1  = wx * dbx;
  assign dt2  = wy * dby;
  assign sqa1 = wx * wx;
  assign sqa2 = wy * wy;
  assign sqb1 = dbx * dbx;
  assign sqb2 = dby * dby;

  assign cross_sum = {cr1[PW-1], cr1} - {cr2[PW-1], cr2};
  assign dot   = -({dt1[PW-1], dt1} + {dt2[PW-1], dt2});
  assign len_a = {1'b0, sqa1} + {1'b0, sqa2};
  assign len_b = {1'b0, sqb1} + {1'b0, sqb2};
  assign at_start = (wx == '0) && (wy == '0);

  always_comb begin
    if (cross_sum != '0) begin
      code = cross_sum[PW] ? sprc_pkg::CODE_OFF_NEG : sprc_pkg::CODE_OFF_POS;
    end else if (dot[PW]) begin
      code = sprc_pkg::CODE_INSIDE;
    end else if (dot == '0) begin
      code = at_start ? sprc_pkg::CODE_AT_BEG : sprc_pkg::CODE_AT_END;
    end else if (len_a <= len_b) begin
      code = sprc_pkg::CODE_BEYOND_BEG;
    end else begin
      code = sprc_pkg::CODE_BEYOND_END;
    end
  end

endmodule

>>> design/sprc_class_map.sv
// tally of code magnitudes and mapping to the relation class
module sprc_class_map (
  input  sprc_pkg::code_set_t codes,
  output sprc_pkg::class_t    relation
);

  logic [1:0] m0, m1, m2, m3;
  logic [2:0] cnt0, cnt1, cnt2, cnt3;
  logic       first_cross, second_cross;

  assign m0 = sprc_pkg::code_mag(codes.first_start);
  assign m1 = sprc_pkg::code_mag(codes.first_end);
  assign m2 = sprc_pkg::code_mag(codes.second_start);
  assign m3 = sprc_pkg::code_mag(codes.second_end);

  assign cnt0 = {2'b0, m0 == 2'd0} + {2'b0, m1 == 2'd0} + {2'b0, m2 == 2'd0}
              + {2'b0, m3 == 2'd0};
  assign cnt1 = {2'b0, m0 == 2'd1} + {2'b0, m1 == 2'd1} + {2'b0, m2 == 2'd1}
              + {2'b0, m3 == 2'd1};
  assign cnt2 = {2'b0, m0 == 2'd2} + {2'b0, m1 == 2'd2} + {2'b0, m2 == 2'd2}
              + {2'b0, m3 == 2'd2};
  assign cnt3 = {2'b0, m0 == 2'd3} + {2'b0, m1 == 2'd3} + {2'b0, m2 == 2'd3}
              + {2'b0, m3 == 2'd3};

  // both endpoints strictly on opposite sides
  assign first_cross =
    ((codes.first_start == sprc_pkg::CODE_OFF_POS) &&
     (codes.first_end == sprc_pkg::CODE_OFF_NEG)) ||
    ((codes.first_start == sprc_pkg::CODE_OFF_NEG) &&
     (codes.first_end == sprc_pkg::CODE_OFF_POS));
  assign second_cross =
    ((codes.second_start == sprc_pkg::CODE_OFF_POS) &&
     (codes.second_end == sprc_pkg::CODE_OFF_NEG)) ||
    ((codes.second_start == sprc_pkg::CODE_OFF_NEG) &&
     (codes.second_end == sprc_pkg::CODE_OFF_POS));

  always_comb begin
    if (first_cross && second_cross) begin
      relation = sprc_pkg::CLS_CROSS;
    end else if (cnt0 == 3'd1 && cnt3 == 3'd3) begin
      relation = sprc_pkg::CLS_TEE;
    end else if (cnt1 == 3'd2 && cnt3 == 3'd2) begin
      relation = sprc_pkg::CLS_CORNER;
    end else if (cnt1 == 3'd2 && cnt2 == 3'd2) begin
      relation = sprc_pkg::CLS_END_TO_END;
    end else if (cnt0 == 3'd2 && cnt2 == 3'd2) begin
      relation = sprc_pkg::CLS_COVER;
    end else if (cnt0 == 3'd1 && cnt1 == 3'd2 && cnt2 == 3'd1) begin
      relation = sprc_pkg::CLS_OVERLAP;
    end else if (cnt1 == 3'd4) begin
      relation = sprc_pkg::CLS_IDENTICAL;
    end else begin
      relation = sprc_pkg::CLS_NONE;
    end
  end

endmodule

>>> design/segment_pair_relation_classifier_unit.sv
// top level of the segment pair relation classifier
//
//   channel   | handshake       | payload
//   ----------+-----------------+---------------------------------------------
//   command   | start / busy    | first_start_x/y, first_end_x/y,
//             |                 | second_start_x/y, second_end_x/y
//   result    | done (strobe)   | relation_class, first_start_code,
//             |                 | first_end_code, second_start_code,
//             |                 | second_end_code
//
// one beat per cycle in, one per cycle out; a beat passes through the input
// register, then the result register; the single multiply-add-compare
// layer between the two registers sets the clock period, not the rate
// rst is synchronous and clears both valid flags; payload is not reset
// busy stays low: nothing inside can hold a beat back
// the receiver cannot stall, so each result shows for exactly one cycle
module segment_pair_relation_classifier_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] first_start_x,
  input  logic signed [COORD_BITS-1:0] first_start_y,
  input  logic signed [COORD_BITS-1:0] first_end_x,
  input  logic signed [COORD_BITS-1:0] first_end_y,
  input  logic signed [COORD_BITS-1:0] second_start_x,
  input  logic signed [COORD_BITS-1:0] second_start_y,
  input  logic signed [COORD_BITS-1:0] second_end_x,
  input  logic signed [COORD_BITS-1:0] second_end_y,
  output logic                         done,
  output logic [3:0]                   relation_class,
  output logic signed [2:0]            first_start_code,
  output logic signed [2:0]            first_end_code,
  output logic signed [2:0]            second_start_code,
  output logic signed [2:0]            second_end_code
);

  // input register
  logic                         in_valid;
  logic signed [COORD_BITS-1:0] fsx, fsy, fex, fey, ssx, ssy, sex, sey;

  // combinational codes and class
  sprc_pkg::code_set_t codes;
  sprc_pkg::class_t    relation;

  // the pipe never blocks
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      fsx <= first_start_x;
      fsy <= first_start_y;
      fex <= first_end_x;
      fey <= first_end_y;
      ssx <= second_start_x;
      ssy <= second_start_y;
      sex <= second_end_x;
      sey <= second_end_y;
    end
  end

  // first segment's endpoints against the second segment
  sprc_point_code #(.COORD_BITS(COORD_BITS)) u_code_fs (
    .p_x(fsx), .p_y(fsy), .a_x(ssx), .a_y(ssy), .b_x(sex), .b_y(sey),
    .code(codes.first_start)
  );
  sprc_point_code #(.COORD_BITS(COORD_BITS)) u_code_fe (
    .p_x(fex), .p_y(fey), .a_x(ssx), .a_y(ssy), .b_x(sex), .b_y(sey),
    .code(codes.first_end)
  );

  // second segment's endpoints against the first segment
  sprc_point_code #(.COORD_BITS(COORD_BITS)) u_code_ss (
    .p_x(ssx), .p_y(ssy), .a_x(fsx), .a_y(fsy), .b_x(fex), .b_y(fey),
    .code(codes.second_start)
  );
  sprc_point_code #(.COORD_BITS(COORD_BITS)) u_code_se (
    .p_x(sex), .p_y(sey), .a_x(fsx), .a_y(fsy), .b_x(fex), .b_y(fey),
    .code(codes.second_end)
  );

  // magnitude tally and class lookup
  sprc_class_map u_class_map (
    .codes   (codes),
    .relation(relation)
  );

  // result register: strobe is reset, payload is not
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      relation_class    <= relation;
      first_start_code  <= codes.first_start;
      first_end_code    <= codes.first_end;
      second_start_code <= codes.second_start;
      second_end_code   <= codes.second_end;
    end
  end

  // a result beat always traces back to a command beat taken through both registers
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("result beat without matching command beat");

  // the duplicate collinear class and codes above eight never appear
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (relation_class != 4'd6) && (relation_class <= 4'd8))
    else $error("relation class out of range");

  // a crossing means every endpoint is off the other line
  a_cross_codes: assert property (@(posedge clk) disable iff (rst)
    (done && relation_class == sprc_pkg::CLS_CROSS) |->
      (sprc_pkg::code_mag(first_start_code) == 2'd3) &&
      (sprc_pkg::code_mag(first_end_code) == 2'd3) &&
      (sprc_pkg::code_mag(second_start_code) == 2'd3) &&
      (sprc_pkg::code_mag(second_end_code) == 2'd3))
    else $error("crossing class with an on-line endpoint");

  // identical segments put every endpoint at an end of the other
  a_identical_codes: assert property (@(posedge clk) disable iff (rst)
    (done && relation_class == sprc_pkg::CLS_IDENTICAL) |->
      (sprc_pkg::code_mag(first_start_code) == 2'd1) &&
      (sprc_pkg::code_mag(first_end_code) == 2'd1) &&
      (sprc_pkg::code_mag(second_start_code) == 2'd1) &&
      (sprc_pkg::code_mag(second_end_code) == 2'd1))
    else $error("identical class with an endpoint not at an end");

  // no code ever takes the unused negative-four pattern
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (first_start_code != 3'sb100) && (first_end_code != 3'sb100) &&
             (second_start_code != 3'sb100) && (second_end_code != 3'sb100))
    else $error("endpoint code out of range");

endmodule
